// ===== sv/sha1x_pkg.sv =====
// Shared types, constants and helpers for the SHA-1 / broken SHA-1 hash block.
package sha1x_pkg;

  // Block and queue geometry.
  localparam int BLK_WORDS = 16;
  localparam int Q_DEPTH   = 2;

  typedef logic [31:0] word_t;

  // Front end: byte packing and block finishing sequence.
  typedef enum logic [1:0] {
    FS_IDLE,
    FS_FULL,
    FS_FINISH,
    FS_LEN
  } fstate_t;

  // Back end: compression rounds and digest output.
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_ROUND,
    BS_ADD,
    BS_OUT
  } bstate_t;

  // One queued block job: the sixteen block words plus how to handle them.
  typedef struct packed {
    logic [BLK_WORDS-1:0][31:0] blk;
    logic                       mode;
    logic                       compress;
    logic                       fin;
  } blk_entry_t;

  // Configuration register indexes.
  localparam logic CFG_HASH_MODE = 1'b0;
  localparam logic CFG_SWAP      = 1'b1;

  // Initial chaining value.
  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hefcdab89;
  localparam word_t IV2 = 32'h98badcfe;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hc3d2e1f0;

  // Round constants.
  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  // Round group boundaries and the final round.
  localparam logic [6:0] ROUND_G1   = 7'd20;
  localparam logic [6:0] ROUND_G2   = 7'd40;
  localparam logic [6:0] ROUND_G3   = 7'd60;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  // Padding constants.
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  // Byte-swap a 32-bit word.
  function automatic word_t swap32(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ===== sv/sha1x_front.sv =====
// Front end: packs message bytes into blocks and queues blocks for compression.
module sha1x_front import sha1x_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_byte,
  input  logic       in_last_byte,
  output logic       push_valid,
  input  logic       push_ready,
  output blk_entry_t push_entry
);

  fstate_t                    state_r, state_nxt;
  logic [BLK_WORDS-1:0][31:0] buf_r, buf_nxt;
  logic [5:0]                 pos_r, pos_nxt;
  logic [60:0]                cnt_r, cnt_nxt;
  logic                       pend_last_r, pend_last_nxt;

  logic                       acc;
  logic                       push_done;
  logic                       pos_high;
  logic [3:0]                 idx;
  logic [1:0]                 lane_sel;
  logic [63:0]                bit_len;
  logic [BLK_WORDS-1:0][31:0] buf_ins;
  logic [BLK_WORDS-1:0][31:0] buf_pad;
  logic [BLK_WORDS-1:0][31:0] len_blk;

  assign acc       = in_valid && in_ready;
  assign push_done = push_valid && push_ready;
  assign pos_high  = (pos_r >= LEN_POS);
  assign idx       = pos_r[5:2];
  assign bit_len   = {cnt_r, 3'b000};

  // Byte lane: big-endian in standard mode, little-endian in broken mode.
  assign lane_sel = mode ? ~pos_r[1:0] : pos_r[1:0];

  // Block buffer with the incoming byte, with the pad byte, and a length-only block.
  always_comb begin
    buf_ins = buf_r;
    buf_ins[idx][{lane_sel, 3'b000} +: 8] = buf_r[idx][{lane_sel, 3'b000} +: 8] | in_data_byte;
    buf_pad = buf_r;
    buf_pad[idx][{~pos_r[1:0], 3'b000} +: 8] = buf_r[idx][{~pos_r[1:0], 3'b000} +: 8] | PAD_BYTE;
    len_blk = '0;
    len_blk[14] = bit_len[63:32];
    len_blk[15] = bit_len[31:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: begin
        if (acc) begin
          if (in_has_byte && (pos_r == LAST_POS)) begin
            state_nxt = FS_FULL;
          end else if (in_last_byte) begin
            state_nxt = FS_FINISH;
          end
        end
      end
      FS_FULL: begin
        if (push_ready) begin
          state_nxt = pend_last_r ? FS_FINISH : FS_IDLE;
        end
      end
      FS_FINISH: begin
        if (push_ready) begin
          state_nxt = (mode && pos_high) ? FS_LEN : FS_IDLE;
        end
      end
      FS_LEN: begin
        if (push_ready) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  // Outputs: handshake and the block job offered to the queue.
  always_comb begin
    in_ready            = (state_r == FS_IDLE);
    push_valid          = (state_r != FS_IDLE);
    push_entry.blk      = buf_r;
    push_entry.mode     = mode;
    push_entry.compress = 1'b1;
    push_entry.fin      = 1'b0;
    case (state_r)
      FS_FULL: begin
        push_entry.blk = buf_r;
      end
      FS_FINISH: begin
        if (mode) begin
          push_entry.blk = buf_pad;
          if (!pos_high) begin
            push_entry.blk[14] = bit_len[63:32];
            push_entry.blk[15] = bit_len[31:0];
          end
          push_entry.fin = !pos_high;
        end else begin
          push_entry.blk      = buf_r;
          push_entry.compress = (pos_r != '0);
          push_entry.fin      = 1'b1;
        end
      end
      FS_LEN: begin
        push_entry.blk = len_blk;
        push_entry.fin = 1'b1;
      end
      default: begin
        push_entry.blk = buf_r;
      end
    endcase
  end

  // Buffer, position and length updates.
  always_comb begin
    buf_nxt       = buf_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    pend_last_nxt = pend_last_r;
    case (state_r)
      FS_IDLE: begin
        if (acc) begin
          pend_last_nxt = in_last_byte;
          if (in_has_byte) begin
            buf_nxt = buf_ins;
            pos_nxt = pos_r + 6'd1;
            cnt_nxt = cnt_r + 61'd1;
          end
        end
      end
      FS_FULL: begin
        if (push_done) begin
          buf_nxt = '0;
        end
      end
      FS_FINISH: begin
        if (push_done) begin
          buf_nxt = '0;
          pos_nxt = '0;
          if (!(mode && pos_high)) begin
            cnt_nxt = '0;
          end
        end
      end
      FS_LEN: begin
        if (push_done) begin
          cnt_nxt = '0;
        end
      end
      default: begin
        buf_nxt = buf_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_IDLE;
      buf_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      pend_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      buf_r       <= buf_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

endmodule

// ===== sv/sha1x_fifo.sv =====
// Short queue of block jobs between the front end and the compression engine.
module sha1x_fifo import sha1x_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  blk_entry_t wr_entry,
  output logic       rd_valid,
  input  logic       rd_ready,
  output blk_entry_t rd_entry
);

  localparam int PW = $clog2(Q_DEPTH);

  blk_entry_t    mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count_r != Q_DEPTH[PW:0]);
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_entry = mem_r[rd_ptr_r];

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ===== sv/sha1x_back.sv =====
// Back end: eighty-round compression engine, chaining value and digest output register.
module sha1x_back import sha1x_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       swap,
  input  logic       rd_valid,
  output logic       rd_ready,
  input  blk_entry_t rd_entry,
  output logic       out_valid,
  input  logic       out_ready,
  output word_t      out_digest_word0,
  output word_t      out_digest_word1,
  output word_t      out_digest_word2,
  output word_t      out_digest_word3,
  output word_t      out_digest_word4
);

  bstate_t                    state_r, state_nxt;
  logic [BLK_WORDS-1:0][31:0] win_r, win_nxt;
  word_t                      a_r, b_r, c_r, d_r, e_r;
  word_t                      a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  word_t                      cv_r [5];
  word_t                      cv_nxt [5];
  word_t                      dig_r [5];
  word_t                      dig_nxt [5];
  logic [6:0]                 rnd_r, rnd_nxt;
  logic                       mode_r, mode_nxt;
  logic                       fin_r, fin_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic                       pop;
  logic                       load;
  word_t                      f;
  word_t                      k;
  word_t                      t;
  word_t                      x;
  word_t                      wnew;

  assign out_valid        = out_valid_r;
  assign out_digest_word0 = dig_r[0];
  assign out_digest_word1 = dig_r[1];
  assign out_digest_word2 = dig_r[2];
  assign out_digest_word3 = dig_r[3];
  assign out_digest_word4 = dig_r[4];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (rd_valid) begin
          if (rd_entry.compress) begin
            state_nxt = BS_ROUND;
          end else if (rd_entry.fin) begin
            state_nxt = BS_OUT;
          end
        end
      end
      BS_ROUND: begin
        if (rnd_r == ROUND_LAST) begin
          state_nxt = BS_ADD;
        end
      end
      BS_ADD: begin
        state_nxt = fin_r ? BS_OUT : BS_IDLE;
      end
      BS_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // Outputs: queue pop and digest register load.
  always_comb begin
    rd_ready = (state_r == BS_IDLE);
    pop      = (state_r == BS_IDLE) && rd_valid;
    load     = (state_r == BS_OUT) && (!out_valid_r || out_ready);
  end

  // Round function, constant and the next schedule word.
  always_comb begin
    if (rnd_r < ROUND_G1) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K0;
    end else if (rnd_r < ROUND_G2) begin
      f = b_r ^ c_r ^ d_r;
      k = K1;
    end else if (rnd_r < ROUND_G3) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K3;
    end
    t    = {a_r[26:0], a_r[31:27]} + f + e_r + k + win_r[0];
    x    = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    // The broken variant turns the XOR value into a one-hot rotation of 1.
    wnew = mode_r ? {x[30:0], x[31]} : (32'd1 << x[4:0]);
  end

  // Datapath updates.
  always_comb begin
    win_nxt       = win_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    cv_nxt        = cv_r;
    dig_nxt       = dig_r;
    rnd_nxt       = rnd_r;
    mode_nxt      = mode_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      BS_IDLE: begin
        if (pop) begin
          win_nxt  = rd_entry.blk;
          mode_nxt = rd_entry.mode;
          fin_nxt  = rd_entry.fin;
          rnd_nxt  = '0;
          a_nxt    = cv_r[0];
          b_nxt    = cv_r[1];
          c_nxt    = cv_r[2];
          d_nxt    = cv_r[3];
          e_nxt    = cv_r[4];
        end
      end
      BS_ROUND: begin
        win_nxt[BLK_WORDS-2:0] = win_r[BLK_WORDS-1:1];
        win_nxt[BLK_WORDS-1]   = wnew;
        a_nxt   = t;
        b_nxt   = a_r;
        c_nxt   = {b_r[1:0], b_r[31:2]};
        d_nxt   = c_r;
        e_nxt   = d_r;
        rnd_nxt = rnd_r + 7'd1;
      end
      BS_ADD: begin
        cv_nxt[0] = cv_r[0] + a_r;
        cv_nxt[1] = cv_r[1] + b_r;
        cv_nxt[2] = cv_r[2] + c_r;
        cv_nxt[3] = cv_r[3] + d_r;
        cv_nxt[4] = cv_r[4] + e_r;
      end
      BS_OUT: begin
        if (load) begin
          for (int i = 0; i < 5; i++) begin
            dig_nxt[i] = swap ? swap32(cv_r[i]) : cv_r[i];
          end
          out_valid_nxt = 1'b1;
          cv_nxt[0] = IV0;
          cv_nxt[1] = IV1;
          cv_nxt[2] = IV2;
          cv_nxt[3] = IV3;
          cv_nxt[4] = IV4;
        end
      end
      default: begin
        rnd_nxt = rnd_r;
      end
    endcase
  end

  // Control state and chaining value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
      cv_r[0]     <= IV0;
      cv_r[1]     <= IV1;
      cv_r[2]     <= IV2;
      cv_r[3]     <= IV3;
      cv_r[4]     <= IV4;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cv_r        <= cv_nxt;
    end
  end

  // Working variables, schedule window and digest payload.
  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    e_r    <= e_nxt;
    dig_r  <= dig_nxt;
    rnd_r  <= rnd_nxt;
    mode_r <= mode_nxt;
    fin_r  <= fin_nxt;
  end

endmodule

// ===== sv/sha1_and_broken_sha1_hash.sv =====
// Top level of the SHA-1 / broken SHA-1 hash block.
// Bytes are taken at one per cycle while the front end is idle; a full 64-byte block goes
// through the round engine as one load, eighty rounds and one chaining add. The padding
// may need a second block; a two-entry block queue lets packing run ahead of compression.
// Synchronous active-low reset clears the buffer, counters and chaining value; no clearing pass.
module sha1_and_broken_sha1_hash import sha1x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word0,
  output logic [31:0] out_digest_word1,
  output logic [31:0] out_digest_word2,
  output logic [31:0] out_digest_word3,
  output logic [31:0] out_digest_word4,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  logic       mode_r, mode_nxt;
  logic       swap_r, swap_nxt;
  logic       push_valid;
  logic       push_ready;
  blk_entry_t push_entry;
  logic       q_valid;
  logic       q_ready;
  blk_entry_t q_entry;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    swap_nxt = swap_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_HASH_MODE: mode_nxt = cfg_data;
        CFG_SWAP:      swap_nxt = cfg_data;
        default:       mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      swap_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      swap_r <= swap_nxt;
    end
  end

  // Byte packing and block finishing.
  sha1x_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .mode         (mode_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_last_byte (in_last_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  // Block job queue.
  sha1x_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_entry (push_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_entry (q_entry)
  );

  // Compression engine and digest output.
  sha1x_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .swap             (swap_r),
    .rd_valid         (q_valid),
    .rd_ready         (q_ready),
    .rd_entry         (q_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digest_word0 (out_digest_word0),
    .out_digest_word1 (out_digest_word1),
    .out_digest_word2 (out_digest_word2),
    .out_digest_word3 (out_digest_word3),
    .out_digest_word4 (out_digest_word4)
  );

  // The front end offers no block while it is taking bytes.
  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !push_valid)
    else $error("front end offers a block while accepting bytes");

  // A job that skips compression must be the one that ends the message.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !push_entry.compress) |-> push_entry.fin)
    else $error("non-compressing block job that does not end the message");

  // A block job offered but refused by a full queue is held unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !push_ready) |=> (push_valid && $stable(push_entry)))
    else $error("block job changed while the queue was full");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the SHA-1 and broken SHA-1 hash block.
module tb_top;
  import sha1x_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned NUM_PHASES   = 8;

  typedef logic [4:0][31:0] digest_t;

  // Keeps a private copy of the hash state, predicts each digest and checks the results.
  class sha1_scoreboard;
    logic        hash_mode;
    logic        swap_words;
    word_t       chain[5];
    word_t       block_words[BLK_WORDS];
    int unsigned fill;
    logic [63:0] bit_count;
    digest_t     expected_digests[$];
    int unsigned mismatches;
    int unsigned digests_checked;
    int unsigned bytes_taken;

    function new();
      hash_mode       = 1'b1;
      swap_words      = 1'b0;
      mismatches      = 0;
      digests_checked = 0;
      bytes_taken     = 0;
      restart();
    endfunction

    // Back to the initial chaining value with an empty block.
    function void restart();
      chain[0] = IV0;
      chain[1] = IV1;
      chain[2] = IV2;
      chain[3] = IV3;
      chain[4] = IV4;
      foreach (block_words[i]) block_words[i] = '0;
      fill      = 0;
      bit_count = '0;
    endfunction

    function void write_reg(logic index, logic value);
      if (index == CFG_HASH_MODE) begin
        hash_mode = value;
      end else if (index == CFG_SWAP) begin
        swap_words = value;
      end
    endfunction

    // Eighty rounds over the block buffer, folded into the chaining value.
    function void compress();
      word_t w[80];
      word_t a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) w[i] = block_words[i];
      for (int i = 16; i < 80; i++) begin
        x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        // The broken variant rotates the constant 1 by the xor value instead.
        w[i] = hash_mode ? {x[30:0], x[31]} : (word_t'(1) << x[4:0]);
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = K0;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = K1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K2;
        end else begin
          f = b ^ c ^ d;
          k = K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
      foreach (block_words[i]) block_words[i] = '0;
    endfunction

    // Bytes go big-endian into words in standard mode, little-endian in the broken one.
    function void pack_byte(int unsigned pos, logic [7:0] value);
      int unsigned lane;
      lane = pos % 4;
      if (hash_mode) begin
        block_words[pos / 4] |= word_t'(value) << (24 - 8 * lane);
      end else begin
        block_words[pos / 4] |= word_t'(value) << (8 * lane);
      end
    endfunction

    // One accepted transaction: absorb the byte and, at the end mark, finish the digest.
    function void note_input(logic [7:0] data, logic has, logic last);
      digest_t d;
      word_t   v;
      if (has) begin
        pack_byte(fill % 64, data);
        bit_count += 64'd8;
        bytes_taken++;
        fill++;
        if (fill >= 64) begin
          compress();
          fill = 0;
        end
      end
      if (!last) return;
      if (!hash_mode) begin
        // No padding at all: only a partial block is compressed, zero-filled.
        if (fill != 0) compress();
      end else begin
        pack_byte(fill, PAD_BYTE);
        if (fill >= LEN_POS) compress();
        block_words[14] = bit_count[63:32];
        block_words[15] = bit_count[31:0];
        compress();
      end
      for (int j = 0; j < 5; j++) begin
        v = chain[j];
        if (swap_words) v = {<<8{v}};
        d[j] = v;
      end
      expected_digests.push_back(d);
      restart();
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    function void check_digest(digest_t got);
      digest_t want;
      digests_checked++;
      if (expected_digests.size() == 0) begin
        report($sformatf("digest %0d arrived with none expected: %h", digests_checked, got));
        return;
      end
      want = expected_digests.pop_front();
      for (int j = 0; j < 5; j++) begin
        if (got[j] !== want[j]) begin
          report($sformatf("digest %0d word%0d: expected %h, got %h",
                           digests_checked, j, want[j], got[j]));
        end
      end
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte  = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [31:0] out_digest_word0;
  logic [31:0] out_digest_word1;
  logic [31:0] out_digest_word2;
  logic [31:0] out_digest_word3;
  logic [31:0] out_digest_word4;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic        cfg_index    = 1'b0;
  logic        cfg_data     = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;

  sha1_scoreboard sb = new();

  sha1_and_broken_sha1_hash dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_has_byte      (in_has_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digest_word0 (out_digest_word0),
    .out_digest_word1 (out_digest_word1),
    .out_digest_word2 (out_digest_word2),
    .out_digest_word3 (out_digest_word3),
    .out_digest_word4 (out_digest_word4),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  // The digest receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Every completed transaction on the three channels keeps the scoreboard in step.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_input(in_data_byte, in_has_byte, in_last_byte);
      if (out_valid && out_ready) begin
        sb.check_digest({out_digest_word4, out_digest_word3, out_digest_word2,
                         out_digest_word1, out_digest_word0});
      end
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Cycle limit hit with %0d digests outstanding.", sb.expected_digests.size());
      $display("sha1_and_broken_sha1_hash: mismatch");
      $finish;
    end
  end

  // Offer one input transaction after a random gap and hold it until taken.
  task automatic send_item(input logic [7:0] data, input logic has, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_has_byte  <= has;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    if (has || last) items_sent++;
  endtask

  // Stop sending until every digest is back and the round engine has gone quiet.
  task automatic drain_digests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers in one burst, so the valid stays high between them.
  task automatic set_hash_options(input logic mode, input logic swap);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HASH_MODE;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_SWAP;
    cfg_data  <= swap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A message of random bytes with the odd idle item; an open one has no end mark.
  task automatic send_message(input int unsigned len, input bit close);
    bit split_end;
    split_end = ($urandom_range(0, 3) == 0) || (len == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, close && !split_end && (i == len - 1));
    end
    if (close && split_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned len;
    int unsigned target;
    int unsigned pick;
    bit          close;
    logic [2:0]  phase_bits;
    int unsigned boundary_lengths[10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Standard mode at reset values: empty message, idle item, short message.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Extreme bytes, then an end mark that carries no byte.
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    drain_digests();

    // Broken mode with swapped words: empty message, then a partial block.
    set_hash_options(1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    // Mode switched half way through a message.
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'h34, 1'b1, 1'b0);
    drain_digests();
    set_hash_options(1'b1, 1'b1);
    send_item(8'h56, 1'b1, 1'b1);
    drain_digests();

    // Random phases, each with its own idling profile and register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_bits = 3'(p);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 72;
          out_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          out_stall_pct = 72;
        end
        default: begin
          send_idle_pct = 29;
          out_stall_pct = 29;
        end
      endcase
      set_hash_options(phase_bits[0] ^ phase_bits[2], phase_bits[1]);
      target = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < target) begin
        // Mostly short messages, with lengths around the padding boundaries now and then.
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          len = $urandom_range(0, 16);
        end else if (pick < 9) begin
          len = boundary_lengths[$urandom_range(0, 9)];
        end else begin
          len = $urandom_range(0, 150);
        end
        // The phase's share of items is not overrun by a long final message.
        if (items_sent + len > target) len = target - items_sent;
        // The last message of a phase may stay open across the register change.
        close = (items_sent + len + 1 < target) || ($urandom_range(0, 1) == 1);
        send_message(len, close);
        if (close && $urandom_range(0, 19) == 0) drain_digests();
      end
      drain_digests();
    end

    $display("Run covered %0d digests and %0d message bytes over %0d random phases,",
             sb.digests_checked, sb.bytes_taken, NUM_PHASES);
    $display("in both hash modes and word orders; %0d mismatches, %0d digests outstanding.",
             sb.mismatches, sb.expected_digests.size());
    if (sb.mismatches == 0 && sb.expected_digests.size() == 0) begin
      $display("sha1_and_broken_sha1_hash: match");
    end else begin
      $display("sha1_and_broken_sha1_hash: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sha1x_pkg.sv
sv/sha1x_front.sv
sv/sha1x_fifo.sv
sv/sha1x_back.sv
sv/sha1_and_broken_sha1_hash.sv
sim/tb_top.sv
